/* rtl/som_pkg.sv */
// Shared types, codes and constants for the self-organizing map engine.
package som_pkg;

  localparam int PADDR_W = 5;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TRAIN = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_MAP_ROWS      = 3'd0;
  localparam logic [2:0] REG_MAP_COLS      = 3'd1;
  localparam logic [2:0] REG_VECTOR_LENGTH = 3'd2;
  localparam logic [2:0] REG_RADIUS_SQUARE = 3'd3;
  localparam logic [2:0] REG_INV_TWO_RSQ   = 3'd4;
  localparam logic [2:0] REG_EFF_RATE      = 3'd5;

  localparam logic [35:0] DIST_MAX  = 36'hF_FFFF_FFFF;
  localparam logic [36:0] DIST_INIT = 37'h10_0000_0000;
  localparam logic [16:0] RATE_ONE  = 17'd65536;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  neuron_index;
    logic [3:0]  component_index;
    logic [15:0] value;
    logic        last_component;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  bmu_index;
    logic [4:0]  bmu_row;
    logic [4:0]  bmu_col;
    logic [13:0] bmu_offset;
    logic [35:0] bmu_distance;
    logic        was_trained;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  map_rows;
    logic [5:0]  map_cols;
    logic [4:0]  vector_length;
    logic [18:0] radius_square;
    logic [15:0] inv_two_radius_square;
    logic [16:0] effective_rate;
  } cfg_t;

  typedef enum logic {OP_LOAD, OP_SAMPLE} op_t;

  typedef struct packed {
    op_t      op;
    logic     train;
    in_item_t item;
  } q_item_t;

  // round(65536*exp(-k/2)); the entry past the end reads as zero
  function automatic logic [16:0] exp_val(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd39750;
      5'd2:    v = 17'd24109;
      5'd3:    v = 17'd14623;
      5'd4:    v = 17'd8869;
      5'd5:    v = 17'd5380;
      5'd6:    v = 17'd3263;
      5'd7:    v = 17'd1979;
      5'd8:    v = 17'd1200;
      5'd9:    v = 17'd728;
      5'd10:   v = 17'd442;
      5'd11:   v = 17'd268;
      5'd12:   v = 17'd162;
      5'd13:   v = 17'd99;
      5'd14:   v = 17'd60;
      5'd15:   v = 17'd36;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/som_bmu_search_and_update.sv */
// Top level of the self-organizing map search and training engine.
// A Kohonen map of up to MAX_ROWS x MAX_COLS neurons, each holding a weight
// vector of up to MAX_DIM words, lives in one on-chip RAM. Load items write
// single weight words. Train and evaluate items deliver sample elements; the
// element marked last starts a search over the whole map, one weight word per
// cycle through a four-stage read/diff/square/accumulate pipeline, a pace set
// by the single RAM read port. The winner is the first neuron with the
// smallest squared distance. A train sample with a nonzero radius then walks
// the map again: every neuron passes through its grid distance and radius
// check, and neurons inside the radius then compute the gain and stream their
// vector_length words through the same pipeline with a read-modify-write of
// the RAM. One result item leaves per completed sample. A two-item queue in
// front keeps taking items while a sample is being worked on, and the output
// register lets the next sample start while a result waits. Weight RAM has no
// reset; read only words that were loaded. Configuration is written over the
// APB port at byte address 4*index and must only change while the block is
// idle.
module som_bmu_search_and_update import som_pkg::*; #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int MAX_DIM     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  cfg_t    cfg;
  logic    q_valid;
  q_item_t q_head;
  logic    q_pop;

  // intake, registers and queue
  som_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // search and update engine with the weight store
  som_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_DIM     (MAX_DIM),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/som_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module som_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/som_front.sv */
// Front end: config registers, item intake, classification and a two-entry queue.
module som_front import som_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output cfg_t               cfg,
  output logic               q_valid,
  output q_item_t            q_head,
  input  logic               q_pop
);

  cfg_t       cfg_r;
  q_item_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       cfg_we;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    unique case (reg_idx)
      REG_MAP_ROWS:      prdata = 32'(cfg_r.map_rows);
      REG_MAP_COLS:      prdata = 32'(cfg_r.map_cols);
      REG_VECTOR_LENGTH: prdata = 32'(cfg_r.vector_length);
      REG_RADIUS_SQUARE: prdata = 32'(cfg_r.radius_square);
      REG_INV_TWO_RSQ:   prdata = 32'(cfg_r.inv_two_radius_square);
      REG_EFF_RATE:      prdata = 32'(cfg_r.effective_rate);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_rows              <= 6'd32;
      cfg_r.map_cols              <= 6'd32;
      cfg_r.vector_length         <= 5'd16;
      cfg_r.radius_square         <= 19'd262144;
      cfg_r.inv_two_radius_square <= 16'd32;
      cfg_r.effective_rate        <= 17'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MAP_ROWS:      cfg_r.map_rows              <= pwdata[5:0];
        REG_MAP_COLS:      cfg_r.map_cols              <= pwdata[5:0];
        REG_VECTOR_LENGTH: cfg_r.vector_length         <= pwdata[4:0];
        REG_RADIUS_SQUARE: cfg_r.radius_square         <= pwdata[18:0];
        REG_INV_TWO_RSQ:   cfg_r.inv_two_radius_square <= pwdata[15:0];
        REG_EFF_RATE:      cfg_r.effective_rate        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // unused action code is taken and dropped here
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_data.action != ACT_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].op    <= (in_data.action == ACT_LOAD) ? OP_LOAD : OP_SAMPLE;
      q_r[wp_r].train <= (in_data.action == ACT_TRAIN);
      q_r[wp_r].item  <= in_data;
    end
  end

endmodule

/* rtl/som_back.sv */
// Back end: weight store, winner search and neighborhood update sequencer.
module som_back import som_pkg::*; #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int MAX_DIM     = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int WORDS = MAX_ROWS * MAX_COLS * MAX_DIM;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int DCW   = $clog2(MAX_DIM + 1);
  localparam int DIW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NCW   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int GW    = (RCW > CCW) ? RCW : CCW;
  localparam int D2W   = 2 * GW + 1;
  localparam int AAW   = D2W + 16;
  localparam int DW    = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int MBW   = (DW > 17) ? DW : 17;
  localparam int PW    = DW + MBW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_S_DRAIN, ST_UPD_D2, ST_UPD_A, ST_UPD_P,
    ST_UPD_H, ST_UPD_G, ST_UPD_W, ST_U_DRAIN, ST_RESULT
  } state_t;

  state_t state_r;

  logic [RCW-1:0] rows_c;
  logic [CCW-1:0] cols_c;
  logic [DCW-1:0] vl_c;
  logic [NCW-1:0] count_c;
  logic [16:0]    rate_c;

  always_comb begin
    if (cfg.map_rows == 6'd0) rows_c = RCW'(1);
    else if (32'(cfg.map_rows) > MAX_ROWS) rows_c = RCW'(MAX_ROWS);
    else rows_c = RCW'(cfg.map_rows);
    if (cfg.map_cols == 6'd0) cols_c = CCW'(1);
    else if (32'(cfg.map_cols) > MAX_COLS) cols_c = CCW'(MAX_COLS);
    else cols_c = CCW'(cfg.map_cols);
    if (cfg.vector_length == 5'd0) vl_c = DCW'(1);
    else if (32'(cfg.vector_length) > MAX_DIM) vl_c = DCW'(MAX_DIM);
    else vl_c = DCW'(cfg.vector_length);
    rate_c = (cfg.effective_rate > RATE_ONE) ? RATE_ONE : cfg.effective_rate;
  end

  assign count_c = NCW'(32'(rows_c) * 32'(cols_c));

  // walk counters
  logic [DCW-1:0] k_r;
  logic [RCW-1:0] r_r;
  logic [CCW-1:0] c_r;
  logic [NCW-1:0] n_r;
  logic [AW-1:0]  base_r;
  logic           train_r;
  logic           last_k, col_last, row_last, nrn_last;

  assign last_k   = (k_r + DCW'(1) == vl_c);
  assign col_last = (c_r + CCW'(1) == cols_c);
  assign row_last = (r_r + RCW'(1) == rows_c);
  assign nrn_last = col_last && row_last;

  // winner
  logic [36:0]    best_dist_r;
  logic [NCW-1:0] best_n_r;
  logic [RCW-1:0] best_row_r;
  logic [CCW-1:0] best_col_r;
  logic [AW-1:0]  best_base_r;

  // gain path
  logic [D2W-1:0] d2_r;
  logic [AAW-1:0] a_r;
  logic           inside_r, hzero_r;
  logic [16:0]    e_lo_r;
  logic [31:0]    prod_r;
  logic [33:0]    hr_r;
  logic [16:0]    g_r;
  logic [RCW-1:0] dr;
  logic [CCW-1:0] dc;
  logic [4:0]     u5;
  logic [16:0]    h;

  assign dr = (r_r > best_row_r) ? r_r - best_row_r : best_row_r - r_r;
  assign dc = (c_r > best_col_r) ? c_r - best_col_r : best_col_r - c_r;
  assign u5 = 5'(a_r >> 15);
  assign h  = hzero_r ? 17'd0 : e_lo_r - 17'((33'(prod_r) + 33'd16384) >> 15);

  // item intake from queue
  logic          is_load, is_sample, load_ok;
  logic [AW-1:0] load_addr;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign is_load   = q_pop && (q_head.op == OP_LOAD);
  assign is_sample = q_pop && (q_head.op == OP_SAMPLE);
  assign load_ok   = is_load && (32'(q_head.item.neuron_index) < 32'(count_c))
                     && (32'(q_head.item.component_index) < 32'(vl_c));
  assign load_addr = AW'(32'(q_head.item.neuron_index) * 32'(vl_c)
                     + 32'(q_head.item.component_index));

  logic [15:0] samp_r [MAX_DIM];

  always_ff @(posedge clk) begin
    if (is_sample && (32'(q_head.item.component_index) < MAX_DIM)) begin
      samp_r[DIW'(q_head.item.component_index)] <= q_head.item.value;
    end
  end

  // word pipeline: issue -> p0 (read) -> p1 (diff) -> p2 (product) -> retire
  logic                   issue_v, issue_upd;
  logic [AW-1:0]          raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic                   p0_v_r, p1_v_r, p2_v_r;
  logic                   p0_upd_r, p1_upd_r, p2_upd_r;
  logic                   p0_last_r, p1_last_r, p2_last_r;
  logic [DCW-1:0]         p0_k_r;
  logic [NCW-1:0]         p0_n_r, p1_n_r, p2_n_r;
  logic [RCW-1:0]         p0_r_r, p1_r_r, p2_r_r;
  logic [CCW-1:0]         p0_c_r, p1_c_r, p2_c_r;
  logic [AW-1:0]          p0_base_r, p1_base_r, p2_base_r;
  logic [AW-1:0]          p0_addr_r, p1_addr_r, p2_addr_r;
  logic [DW-1:0]          p1_d_r, p1_w_r, p2_w_r;
  logic                   p1_neg_r, p2_neg_r;
  logic [PW-1:0]          p2_prod_r;
  logic [35:0]            acc_r;
  logic                   pipe_empty;

  assign issue_v    = (state_r == ST_SEARCH) || (state_r == ST_UPD_W);
  assign issue_upd  = (state_r == ST_UPD_W);
  assign raddr      = base_r + AW'(k_r);
  assign pipe_empty = !p0_v_r && !p1_v_r && !p2_v_r;

  logic [DW-1:0]  wx, xx;
  logic [MBW-1:0] mul_b;
  logic [35:0]    sq36, sum36;
  logic [36:0]    sum37;
  logic [PW:0]    step;
  logic [DW:0]    nw;
  logic           srch_ret, upd_we, better;

  assign wx    = DW'(rdata);
  assign xx    = DW'(samp_r[p0_k_r[DIW-1:0]]);
  assign mul_b = p1_upd_r ? MBW'(g_r) : MBW'(p1_d_r);

  assign sq36  = (64'(p2_prod_r) > 64'(DIST_MAX)) ? DIST_MAX : 36'(p2_prod_r);
  assign sum37 = {1'b0, acc_r} + {1'b0, sq36};
  assign sum36 = (sum37 > {1'b0, DIST_MAX}) ? DIST_MAX : sum37[35:0];
  assign srch_ret = p2_v_r && !p2_upd_r;
  assign better   = srch_ret && p2_last_r && ({1'b0, sum36} < best_dist_r);

  assign step   = ({1'b0, p2_prod_r} + (PW+1)'(32768)) >> 16;
  assign nw     = p2_neg_r ? {1'b0, p2_w_r} - (DW+1)'(step)
                           : {1'b0, p2_w_r} + (DW+1)'(step);
  assign upd_we = p2_v_r && p2_upd_r;

  som_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WORDS)) u_wram (
    .clk   (clk),
    .we    (load_ok || upd_we),
    .waddr (upd_we ? p2_addr_r : load_addr),
    .wdata (upd_we ? WEIGHT_BITS'(nw) : WEIGHT_BITS'(q_head.item.value)),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      p0_v_r <= issue_v;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
      if (srch_ret) acc_r <= p2_last_r ? 36'd0 : sum36;
    end
  end

  always_ff @(posedge clk) begin
    p0_upd_r  <= issue_upd;
    p0_last_r <= last_k;
    p0_k_r    <= k_r;
    p0_n_r    <= n_r;
    p0_r_r    <= r_r;
    p0_c_r    <= c_r;
    p0_base_r <= base_r;
    p0_addr_r <= raddr;
    p1_upd_r  <= p0_upd_r;
    p1_last_r <= p0_last_r;
    p1_n_r    <= p0_n_r;
    p1_r_r    <= p0_r_r;
    p1_c_r    <= p0_c_r;
    p1_base_r <= p0_base_r;
    p1_addr_r <= p0_addr_r;
    p1_w_r    <= wx;
    p1_neg_r  <= (xx < wx);
    p1_d_r    <= (xx >= wx) ? xx - wx : wx - xx;
    p2_upd_r  <= p1_upd_r;
    p2_last_r <= p1_last_r;
    p2_n_r    <= p1_n_r;
    p2_r_r    <= p1_r_r;
    p2_c_r    <= p1_c_r;
    p2_base_r <= p1_base_r;
    p2_addr_r <= p1_addr_r;
    p2_w_r    <= p1_w_r;
    p2_neg_r  <= p1_neg_r;
    p2_prod_r <= PW'(p1_d_r) * PW'(mul_b);
  end

  out_item_t out_data_r;
  logic      out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      best_dist_r <= '0;
      best_n_r    <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      best_base_r <= '0;
      train_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_RESULT)) out_valid_r <= 1'b0;
      if (better) begin
        best_dist_r <= {1'b0, sum36};
        best_n_r    <= p2_n_r;
        best_row_r  <= p2_r_r;
        best_col_r  <= p2_c_r;
        best_base_r <= p2_base_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (is_sample && q_head.item.last_component) begin
            train_r     <= q_head.train && (cfg.radius_square != 19'd0);
            best_dist_r <= DIST_INIT;
            best_n_r    <= '0;
            best_row_r  <= '0;
            best_col_r  <= '0;
            best_base_r <= '0;
            k_r         <= '0;
            r_r         <= '0;
            c_r         <= '0;
            n_r         <= '0;
            base_r      <= '0;
            state_r     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (last_k) begin
            k_r    <= '0;
            n_r    <= n_r + NCW'(1);
            base_r <= base_r + AW'(vl_c);
            if (col_last) begin
              c_r <= '0;
              r_r <= r_r + RCW'(1);
            end else begin
              c_r <= c_r + CCW'(1);
            end
            if (nrn_last) state_r <= ST_S_DRAIN;
          end else begin
            k_r <= k_r + DCW'(1);
          end
        end
        ST_S_DRAIN: begin
          if (pipe_empty) begin
            k_r    <= '0;
            r_r    <= '0;
            c_r    <= '0;
            base_r <= '0;
            state_r <= train_r ? ST_UPD_D2 : ST_RESULT;
          end
        end
        ST_UPD_D2: begin
          d2_r    <= D2W'(dr) * D2W'(dr) + D2W'(dc) * D2W'(dc);
          state_r <= ST_UPD_A;
        end
        ST_UPD_A: begin
          a_r      <= AAW'(d2_r) * AAW'(cfg.inv_two_radius_square);
          inside_r <= ({d2_r, 8'd0} < (D2W+8)'(cfg.radius_square))
                      && ((D2W+8) >= 19 || (cfg.radius_square >> (D2W+8)) == 19'd0
                          || d2_r == '0);
          state_r  <= ST_UPD_P;
        end
        ST_UPD_P: begin
          if (!inside_r) begin
            base_r <= base_r + AW'(vl_c);
            if (col_last) begin
              c_r <= '0;
              r_r <= r_r + RCW'(1);
            end else begin
              c_r <= c_r + CCW'(1);
            end
            state_r <= nrn_last ? ST_U_DRAIN : ST_UPD_D2;
          end else begin
            hzero_r <= ((a_r >> 15) >= AAW'(16));
            e_lo_r  <= exp_val(u5);
            prod_r  <= 32'(exp_val(u5) - exp_val(u5 + 5'd1)) * 32'(a_r[14:0]);
            state_r <= ST_UPD_H;
          end
        end
        ST_UPD_H: begin
          hr_r    <= 34'(h) * 34'(rate_c);
          state_r <= ST_UPD_G;
        end
        ST_UPD_G: begin
          g_r     <= 17'((35'(hr_r) + 35'd32768) >> 16);
          k_r     <= '0;
          state_r <= ST_UPD_W;
        end
        ST_UPD_W: begin
          if (last_k) begin
            k_r    <= '0;
            base_r <= base_r + AW'(vl_c);
            if (col_last) begin
              c_r <= '0;
              r_r <= r_r + RCW'(1);
            end else begin
              c_r <= c_r + CCW'(1);
            end
            state_r <= nrn_last ? ST_U_DRAIN : ST_UPD_D2;
          end else begin
            k_r <= k_r + DCW'(1);
          end
        end
        ST_U_DRAIN: begin
          if (pipe_empty) state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.bmu_index    <= 10'(best_n_r);
            out_data_r.bmu_row      <= 5'(best_row_r);
            out_data_r.bmu_col      <= 5'(best_col_r);
            out_data_r.bmu_offset   <= 14'(best_base_r);
            out_data_r.bmu_distance <= best_dist_r[35:0];
            out_data_r.was_trained  <= train_r;
            out_valid_r             <= 1'b1;
            state_r                 <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> pipe_empty)
    else $error("word pipeline busy while idle");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> (best_dist_r <= {1'b0, DIST_MAX}))
    else $error("winner distance out of range at result");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_W) |-> (g_r <= RATE_ONE))
    else $error("neighborhood gain above one");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && state_r != ST_RESULT) |=> !out_valid_r)
    else $error("result repeated after delivery");

endmodule
